/* rtl/core/smash_pkg.sv */
// Shared constants, types and command codes for the simhash fingerprint accumulator.
`timescale 1ns / 1ps

package smash_pkg;

    // Digest and counter geometry.
    localparam int DIGEST_BYTES = 20;
    localparam int WORD_BITS    = 32;
    localparam int COUNTER_BITS = 8;
    localparam int WEIGHT_BITS  = 8;
    localparam int NUM_CTR      = DIGEST_BYTES * 8;
    localparam int NUM_WORDS    = (NUM_CTR + WORD_BITS - 1) / WORD_BITS;

    // Field and index widths.
    localparam int IDX_W  = 3;
    localparam int WCNT_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    // Fingerprint queue between the cell row and the output port.
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef logic [WORD_BITS-1:0]                 t_word;
    typedef logic [COUNTER_BITS-1:0]              t_ctr;
    typedef logic [WEIGHT_BITS-1:0]               t_weight;
    typedef logic [NUM_WORDS-1:0][WORD_BITS-1:0]  t_fp;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_EMIT = 1'b1
    } t_cmd;

    // One beat as it travels along the row of cells.
    typedef struct packed {
        logic             valid;
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
        t_word            word;
        t_weight          weight;
        t_fp              fp;
    } t_beat;

endpackage

/* rtl/core/smash_cell.sv */
// One cell of the counter row: holds the counters of one digest word.
`timescale 1ns / 1ps

module smash_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [smash_pkg::IDX_W-1:0]   i_cell_idx,
    input  smash_pkg::t_beat              i_beat,
    output smash_pkg::t_beat              o_beat
);

    smash_pkg::t_ctr  r_ctr [smash_pkg::WORD_BITS];
    smash_pkg::t_ctr  n_ctr [smash_pkg::WORD_BITS];
    smash_pkg::t_beat r_beat;
    smash_pkg::t_beat n_beat;
    smash_pkg::t_word w_pos;
    smash_pkg::t_ctr  w_weight;
    logic             w_hit;
    logic             w_emit;

    // Decode the beat: an add for this word, or an emit that reads and clears.
    always_comb begin
        w_hit    = i_beat.valid && (i_beat.cmd == smash_pkg::CMD_ADD)
                   && (i_beat.idx == i_cell_idx);
        w_emit   = i_beat.valid && (i_beat.cmd == smash_pkg::CMD_EMIT);
        w_weight = smash_pkg::t_ctr'(i_beat.weight);
    end

    // Counter update and positivity test; the first digest bit is the word's MSB.
    always_comb begin
        for (int j = 0; j < smash_pkg::WORD_BITS; j++) begin
            logic in_range;
            logic dbit;
            in_range = ((int'(i_cell_idx) * smash_pkg::WORD_BITS + j) < smash_pkg::NUM_CTR);
            dbit     = i_beat.word[smash_pkg::WORD_BITS-1-j];
            w_pos[smash_pkg::WORD_BITS-1-j] = in_range && (r_ctr[j] != '0)
                                             && !r_ctr[j][smash_pkg::COUNTER_BITS-1];
            if (w_emit) begin
                n_ctr[j] = '0;
            end else if (w_hit && in_range) begin
                n_ctr[j] = dbit ? (r_ctr[j] + w_weight) : (r_ctr[j] - w_weight);
            end else begin
                n_ctr[j] = r_ctr[j];
            end
        end
    end

    // Pass the beat on, filling in this cell's fingerprint word on an emit.
    always_comb begin
        n_beat = i_beat;
        if (w_emit) begin
            n_beat.fp[i_cell_idx] = w_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < smash_pkg::WORD_BITS; j++) begin
                r_ctr[j] <= '0;
            end
            r_beat.valid <= 1'b0;
        end else begin
            r_ctr  <= n_ctr;
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

/* rtl/core/smash_out_stage.sv */
// Fingerprint queue and word serialiser that drives the result channel.
`timescale 1ns / 1ps

module smash_out_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  smash_pkg::t_fp                i_fp,
    input  logic                          i_stall,
    output logic                          o_valid,
    output smash_pkg::t_word              o_word,
    output logic [smash_pkg::IDX_W-1:0]   o_index,
    output logic                          o_last,
    output logic                          o_free
);

    smash_pkg::t_fp                  r_fp [smash_pkg::FIFO_DEPTH];
    logic [smash_pkg::PTR_W-1:0]     r_wr_ptr;
    logic [smash_pkg::PTR_W-1:0]     r_rd_ptr;
    logic [smash_pkg::CNT_W-1:0]     r_count;
    logic [smash_pkg::WCNT_W-1:0]    r_word_cnt;
    logic [smash_pkg::PTR_W-1:0]     n_wr_ptr;
    logic [smash_pkg::PTR_W-1:0]     n_rd_ptr;
    logic [smash_pkg::CNT_W-1:0]     n_count;
    logic [smash_pkg::WCNT_W-1:0]    n_word_cnt;
    logic                            w_pop;

    // Present the current word of the oldest fingerprint.
    always_comb begin
        o_valid = (r_count != '0);
        o_word  = r_fp[r_rd_ptr][r_word_cnt];
        o_index = smash_pkg::IDX_W'(r_word_cnt);
        o_last  = (r_word_cnt == smash_pkg::WCNT_W'(smash_pkg::NUM_WORDS - 1));
        w_pop   = o_valid && !i_stall;
        o_free  = w_pop && o_last;
    end

    // Pointer, occupancy and word counter bookkeeping.
    always_comb begin
        n_wr_ptr   = r_wr_ptr;
        n_rd_ptr   = r_rd_ptr;
        n_word_cnt = r_word_cnt;
        n_count    = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == smash_pkg::PTR_W'(smash_pkg::FIFO_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            if (o_last) begin
                n_word_cnt = '0;
                n_rd_ptr   = (r_rd_ptr == smash_pkg::PTR_W'(smash_pkg::FIFO_DEPTH - 1))
                             ? '0 : r_rd_ptr + 1'b1;
            end else begin
                n_word_cnt = r_word_cnt + 1'b1;
            end
        end
        if (i_push && !o_free) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && o_free) begin
            n_count = r_count - 1'b1;
        end
    end

    // Fingerprint storage; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_fp[r_wr_ptr] <= i_fp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
            r_word_cnt <= '0;
        end else begin
            r_wr_ptr   <= n_wr_ptr;
            r_rd_ptr   <= n_rd_ptr;
            r_count    <= n_count;
            r_word_cnt <= n_word_cnt;
        end
    end

endmodule

/* rtl/core/simhash_fingerprint_accumulator_core.sv */
// Top level of the 160-bit simhash fingerprint accumulator.
`timescale 1ns / 1ps
//
// Usage: the input channel takes one beat per cycle while it does not stall. An add
// beat (cmd 0) carries one 32-bit digest word, its word index (0 to 4) and the
// token weight; every bit adds +weight or -weight to its own 8-bit wrapping
// counter. An add with a word index of five or more changes nothing. An emit beat
// (cmd 1) reads the 160 counters out as five fingerprint words on the result
// channel, index 0 first and o_last on the fifth, and clears the counters behind it.
// Throughput: one input beat per cycle while the input does not stall. The counters
// sit in a row of five cells, one per digest word, and every beat walks the row one
// cell per cycle, so beats that follow an emit see cleared counters. Results
// leave at one word per cycle unless the receiver stalls.
// Order: an emit beat passes through the five registered cells and is then written
// into the queue, which presents its first word; the other four words follow on
// consecutive cycles unless the receiver stalls.
// Stall: two finished fingerprints can be held. While two emits are outstanding the
// input channel stalls; a stalled result word holds steady.
// Reset: synchronous and active low; all counters are cleared and no result is
// pending.

module simhash_fingerprint_accumulator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic [smash_pkg::IDX_W-1:0]   i_word_index,
    input  smash_pkg::t_word              i_digest_word,
    input  smash_pkg::t_weight            i_weight,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output smash_pkg::t_word              o_fingerprint_word,
    output logic [smash_pkg::IDX_W-1:0]   o_out_index,
    output logic                          o_last
);

    smash_pkg::t_beat             w_link [smash_pkg::NUM_WORDS+1];
    logic [smash_pkg::CNT_W-1:0]  r_resv;
    logic [smash_pkg::CNT_W-1:0]  n_resv;
    logic                         w_accept;
    logic                         w_emit_in;
    logic                         w_push;
    logic                         w_free;

    // Input handshake; stall while every fingerprint slot is spoken for.
    always_comb begin
        o_in_stall = (r_resv == smash_pkg::CNT_W'(smash_pkg::FIFO_DEPTH));
        w_accept   = i_in_valid && !o_in_stall;
        w_emit_in  = w_accept && (smash_pkg::t_cmd'(i_cmd) == smash_pkg::CMD_EMIT);
    end

    // Build the beat that enters the first cell.
    always_comb begin
        w_link[0].valid  = w_accept;
        w_link[0].cmd    = smash_pkg::t_cmd'(i_cmd);
        w_link[0].idx    = i_word_index;
        w_link[0].word   = i_digest_word;
        w_link[0].weight = i_weight;
        w_link[0].fp     = '0;
    end

    // The row of counter cells, one per digest word.
    for (genvar k = 0; k < smash_pkg::NUM_WORDS; k++) begin : g_cell
        smash_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (smash_pkg::IDX_W'(k)),
            .i_beat     (w_link[k]),
            .o_beat     (w_link[k+1])
        );
    end

    // A complete fingerprint leaves the last cell.
    assign w_push = w_link[smash_pkg::NUM_WORDS].valid
                    && (w_link[smash_pkg::NUM_WORDS].cmd == smash_pkg::CMD_EMIT);

    smash_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_fp    (w_link[smash_pkg::NUM_WORDS].fp),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_word  (o_fingerprint_word),
        .o_index (o_out_index),
        .o_last  (o_last),
        .o_free  (w_free)
    );

    // Count of emits taken whose last word has not yet been delivered.
    always_comb begin
        n_resv = r_resv;
        if (w_emit_in && !w_free) begin
            n_resv = r_resv + 1'b1;
        end else if (!w_emit_in && w_free) begin
            n_resv = r_resv - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resv <= '0;
        end else begin
            r_resv <= n_resv;
        end
    end

endmodule

/* rtl/core/smash_checker.sv */
// Port-level checks on the result channel of the accumulator, bound to the top level.
`timescale 1ns / 1ps

module smash_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input smash_pkg::t_word              o_fingerprint_word,
    input logic [smash_pkg::IDX_W-1:0]   o_out_index,
    input logic                          o_last
);

    // A stalled result beat holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_fingerprint_word) && $stable(o_out_index)
         && $stable(o_last)))
        else $error("result beat changed while stalled");

    // The last flag marks exactly the final word index.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        (o_last == (o_out_index == smash_pkg::IDX_W'(smash_pkg::NUM_WORDS - 1))))
        else $error("last flag does not match word index");

    // Words of one fingerprint follow each other without gaps, in index order.
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=>
        (o_out_valid && (o_out_index == $past(o_out_index) + 3'd1)))
        else $error("fingerprint words out of order");

    // The first beat after a finished fingerprint starts at word zero.
    a_word_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |=>
        (!o_out_valid || (o_out_index == '0)))
        else $error("fingerprint does not start at word zero");

endmodule

bind simhash_fingerprint_accumulator_core smash_checker u_smash_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_fingerprint_word (o_fingerprint_word),
    .o_out_index        (o_out_index),
    .o_last             (o_last)
);
